### src/cbeq_pkg.sv
// Shared types and constants for the cascaded biquad equalizer.
`default_nettype none
package cbeq_pkg;

    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned COEF_W   = 32;
    localparam int unsigned STATE_W  = 48;
    localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
    localparam int unsigned PROD_SHIFT = 15;
    localparam int unsigned OUT_SHIFT  = 12;
    localparam int unsigned COEFS_PER_BAND = 5;

    localparam logic [1:0] FUNC_FILTER = 2'd0;
    localparam logic [1:0] FUNC_COEF   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh0800_0000;

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [2:0]                 band_sel;
        logic [2:0]                 coef_sel;
        logic signed [COEF_W-1:0]   coef_value;
    } req_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } req_out_t;

    // Sample and clip flag handed from one band cell to the next.
    typedef struct packed {
        logic                       vld;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       clip;
    } link_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic                       wr;
        logic [2:0]                 coef_sel;
        logic signed [COEF_W-1:0]   coef_value;
        logic                       clear;
    } cell_ctl_t;

endpackage
`default_nettype wire

### src/cascaded_biquad_equalizer_unit.sv
// Top level of the cascaded biquad equalizer: request control and the band chain.
`default_nettype none
// A filter request runs through BANDS band cells in series; each band uses
// one shared 32x24 multiplier five times, plus output rounding and state
// update. Coefficient writes and history clears give no result. One request
// is processed at a time; the result waits in an output register, and no new
// request is accepted until the receiver takes it, at the earliest in the same
// cycle.
module cascaded_biquad_equalizer_unit #(
    parameter int BANDS = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cbeq_pkg::req_in_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cbeq_pkg::req_out_t      out_data
);
    import cbeq_pkg::*;

    logic      busy_reg, busy_next;
    logic      filt_reg;
    cell_ctl_t ctl_reg;
    logic [2:0] band_reg;
    link_t     head_reg;
    link_t     links [BANDS+1];
    logic      ovld_reg;
    req_out_t  odata_reg;
    logic      acc;

    assign acc      = in_valid && in_ready;
    assign in_ready = !busy_reg && !(ovld_reg && !out_ready);
    assign links[0] = head_reg;

    // Decode the request and start the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            filt_reg <= 1'b0;
            ctl_reg  <= '0;
            head_reg <= '0;
            band_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (acc)
            begin
                filt_reg      <= (in_data.func == FUNC_FILTER);
                head_reg.vld  <= (in_data.func == FUNC_FILTER);
                head_reg.smp  <= in_data.sample_in;
                head_reg.clip <= 1'b0;
                ctl_reg.wr    <= (in_data.func == FUNC_COEF) &&
                                 (32'(in_data.band_sel) < 32'(BANDS)) &&
                                 (in_data.coef_sel <= COEF_A2);
                ctl_reg.clear <= (in_data.func == FUNC_CLEAR);
                band_reg           <= in_data.band_sel;
                ctl_reg.coef_sel   <= in_data.coef_sel;
                ctl_reg.coef_value <= in_data.coef_value;
            end
            else
            begin
                head_reg.vld  <= 1'b0;
                ctl_reg.wr    <= 1'b0;
                ctl_reg.clear <= 1'b0;
                if (links[BANDS].vld)
                    filt_reg <= 1'b0;
            end
        end
    end

    // Busy from a filter request until its result leaves the chain; one cycle otherwise.
    always_comb
    begin
        busy_next = busy_reg;
        if (acc)
            busy_next = 1'b1;
        else if (links[BANDS].vld || (busy_reg && !filt_reg))
            busy_next = 1'b0;
    end

    // Band cells in series.
    for (genvar g = 0; g < BANDS; g++)
    begin : g_band
        cbeq_band u_band (
            .clk      (clk),
            .rst_n    (rst_n),
            .sel      (32'(band_reg) == 32'(g)),
            .ctl      (ctl_reg),
            .link_in  (links[g]),
            .link_out (links[g+1])
        );
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (links[BANDS].vld)
            ovld_reg <= 1'b1;
        else if (out_ready)
            ovld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (links[BANDS].vld)
        begin
            odata_reg.sample_out <= links[BANDS].smp;
            odata_reg.clipped    <= links[BANDS].clip;
        end
    end

    assign out_valid = ovld_reg;
    assign out_data  = odata_reg;

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (ovld_reg && !out_ready) |-> !links[BANDS].vld) else $error("result lost");
    a_busy_accept: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ready) else $error("accept while busy");
    a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg.vld |=> !head_reg.vld) else $error("double start");
`endif

endmodule
`default_nettype wire

### src/cbeq_band.sv
// One biquad band cell: coefficients, delay state and a shared multiplier sequence.
`default_nettype none
module cbeq_band (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sel,
    input  wire cbeq_pkg::cell_ctl_t ctl,
    input  wire cbeq_pkg::link_t   link_in,
    output cbeq_pkg::link_t        link_out
);
    import cbeq_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_B0, S_OUT, S_B1, S_B2, S_A1, S_A2, S_DONE} state_t;

    localparam logic signed [STATE_W:0] S48_MAX = {2'b00, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W:0] S48_MIN = {2'b11, {(STATE_W-1){1'b0}}};

    state_t                      state_reg;
    logic signed [COEF_W-1:0]    c_reg [COEFS_PER_BAND];
    logic signed [STATE_W-1:0]   d1_reg, d2_reg;
    logic signed [SAMPLE_W-1:0]  x_reg, y_reg;
    logic signed [STATE_W:0]     acc_reg;
    logic                        clip_reg;
    link_t                       out_reg;

    logic signed [COEF_W-1:0]    mc;
    logic signed [SAMPLE_W-1:0]  mx;
    logic signed [PROD_W-1:0]    prod;
    logic signed [STATE_W:0]     term;
    logic signed [STATE_W:0]     sum;
    logic signed [STATE_W:0]     rnd;
    logic signed [STATE_W:0]     sat48;
    logic                        ovf48;
    logic signed [SAMPLE_W-1:0]  ysat;
    logic                        ovf24;

    // Select multiplier operands for the current step.
    always_comb
    begin
        mc = c_reg[0];
        mx = x_reg;
        case (state_reg)
            S_B0:    begin mc = c_reg[0]; mx = x_reg; end
            S_B1:    begin mc = c_reg[1]; mx = x_reg; end
            S_B2:    begin mc = c_reg[2]; mx = x_reg; end
            S_A1:    begin mc = c_reg[3]; mx = y_reg; end
            S_A2:    begin mc = c_reg[4]; mx = y_reg; end
            default: begin mc = c_reg[0]; mx = x_reg; end
        endcase
        prod = PROD_W'(mc) * PROD_W'(mx);
        term = (STATE_W+1)'(prod >>> PROD_SHIFT);
        sum  = acc_reg - term;
        // Round the accumulator half up and saturate to 24 bits.
        rnd  = (acc_reg + (STATE_W+1)'(1 << (OUT_SHIFT-1))) >>> OUT_SHIFT;
        ovf24 = (rnd > (STATE_W+1)'(8388607)) || (rnd < -(STATE_W+1)'(8388608));
        if (rnd > (STATE_W+1)'(8388607))
            ysat = 24'sh7FFFFF;
        else if (rnd < -(STATE_W+1)'(8388608))
            ysat = 24'sh800000;
        else
            ysat = rnd[SAMPLE_W-1:0];
        ovf48 = (acc_reg > S48_MAX) || (acc_reg < S48_MIN);
        if (acc_reg > S48_MAX)
            sat48 = S48_MAX;
        else if (acc_reg < S48_MIN)
            sat48 = S48_MIN;
        else
            sat48 = acc_reg;
    end

    // Coefficient store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEFS_PER_BAND; i++)
                c_reg[i] <= (i == 0) ? COEF_ONE : '0;
        end
        else if (ctl.wr && sel)
        begin
            for (int i = 0; i < COEFS_PER_BAND; i++)
                if (ctl.coef_sel == 3'(i))
                    c_reg[i] <= ctl.coef_value;
        end
    end

    // Step through one band: b0, output, b1, a1, b2, a2, done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            d1_reg    <= '0;
            d2_reg    <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            acc_reg   <= '0;
            clip_reg  <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            out_reg.vld <= (state_reg == S_DONE);
            case (state_reg)
                S_IDLE:
                begin
                    if (ctl.clear)
                    begin
                        d1_reg <= '0;
                        d2_reg <= '0;
                    end
                    else if (link_in.vld)
                    begin
                        x_reg     <= link_in.smp;
                        clip_reg  <= link_in.clip;
                        acc_reg   <= (STATE_W+1)'(d1_reg);
                        state_reg <= S_B0;
                    end
                end
                S_B0:
                begin
                    acc_reg   <= acc_reg + term;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    y_reg     <= ysat;
                    clip_reg  <= clip_reg | ovf24;
                    acc_reg   <= (STATE_W+1)'(d2_reg);
                    state_reg <= S_B1;
                end
                S_B1:
                begin
                    acc_reg   <= acc_reg + term;
                    state_reg <= S_A1;
                end
                S_A1:
                begin
                    acc_reg   <= sum;
                    state_reg <= S_B2;
                end
                S_B2:
                begin
                    d1_reg    <= sat48[STATE_W-1:0];
                    clip_reg  <= clip_reg | ovf48;
                    acc_reg   <= term;
                    state_reg <= S_A2;
                end
                S_A2:
                begin
                    acc_reg   <= sum;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    d2_reg      <= sat48[STATE_W-1:0];
                    out_reg.smp <= y_reg;
                    out_reg.clip <= clip_reg | ovf48;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign link_out = out_reg;

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        link_out.vld |=> !link_out.vld) else $error("band output held");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && link_in.vld && !ctl.clear) |=> state_reg == S_B0)
        else $error("band did not start");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_A2 |=> state_reg == S_DONE) else $error("band sequence slip");
`endif

endmodule
`default_nettype wire
